// ===== rtl/brbf_pkg.sv =====
// Shared constants and payload types for the byte ring buffer FIFO.
// No dependencies; imported by the top level and its checker.
package brbf_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int MAX_REQUEST = 64;

   localparam int PTR_W  = $clog2(STORE_DEPTH);
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = 11;

   localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              has_byte;
      logic [LEN_W-1:0]  moved_count;
      logic [CNT_W-1:0]  fill_level;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/brbf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module brbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/byte_ring_buffer_fifo.sv =====
// Byte ring buffer FIFO top level: command decode, pointers and result register.
// Depends on brbf_pkg and brbf_ram.

// A command is taken when start is high, busy is low and no capacity write is
// made. Push, discard and the unused code can follow back to back; their single
// result appears with rsp_strobe in the next cycle. A pop that moves n bytes keeps
// busy high through its n reads of the byte store, one read each cycle, and each
// result follows in the cycle after its read, the last one marked; a pop of nothing
// gives one result in the next cycle. Results cannot be held off, so every strobe
// is a transfer. Writing the capacity register while idle empties the FIFO; the
// byte store needs no clearing after reset.
module byte_ring_buffer_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  brbf_pkg::req_type           req_payload,
   output logic                        rsp_strobe,
   output brbf_pkg::rsp_type           rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [brbf_pkg::CNT_W-1:0]  csr_write_data
);
   import brbf_pkg::*;

   typedef enum logic {ST_IDLE, ST_POP} state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]   slots_ff, slots_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_has_ff, rsp_has_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_moved_ff, rsp_moved_in;
   logic [CNT_W-1:0]   rsp_fill_ff, rsp_fill_in;

   logic               ram_we;
   logic               ram_re;
   logic [BYTE_W-1:0]  ram_rd_data;

   logic [LEN_W-1:0]   len_sat;
   logic [LEN_W-1:0]   take;
   logic [CNT_W-1:0]   held_left;
   logic [CNT_W-1:0]   rd_sum;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] slots);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(p) + CNT_W'(1);
      return (nxt >= slots) ? '0 : nxt[PTR_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_capacity(input logic [CNT_W-1:0] c);
      if (c == '0) begin
         return CNT_W'(1);
      end
      if (c > CNT_W'(STORE_DEPTH)) begin
         return CNT_W'(STORE_DEPTH);
      end
      return c;
   endfunction

   brbf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_payload.data_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // bytes actually moved by a pop or discard
   always_comb begin
      len_sat   = (req_payload.length > LEN_W'(MAX_REQUEST)) ? LEN_W'(MAX_REQUEST)
                                                             : req_payload.length;
      take      = (CNT_W'(len_sat) < held_ff) ? len_sat : held_ff[LEN_W-1:0];
      held_left = held_ff - CNT_W'(take);
      rd_sum    = CNT_W'(rd_ptr_ff) + CNT_W'(take);
   end

   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      held_in       = held_ff;
      slots_in      = slots_ff;
      remain_in     = remain_ff;
      rsp_strobe_in = 1'b0;
      rsp_has_in    = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_moved_in  = rsp_moved_ff;
      rsp_fill_in   = rsp_fill_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               slots_in  = sat_capacity(csr_write_data);
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               held_in   = '0;
            end else if (start) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_moved_in  = '0;
               rsp_fill_in   = held_ff;
               case (req_payload.command)
                  CMD_PUSH: begin
                     if (held_ff < slots_ff) begin
                        ram_we       = 1'b1;
                        wr_ptr_in    = advance(wr_ptr_ff, slots_ff);
                        held_in      = held_ff + CNT_W'(1);
                        rsp_moved_in = LEN_W'(1);
                        rsp_fill_in  = held_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP: begin
                     if (take != '0) begin
                        // results come out of the read loop, not now
                        rsp_strobe_in = 1'b0;
                        rsp_last_in   = 1'b0;
                        state_in      = ST_POP;
                        remain_in     = take;
                        rsp_moved_in  = take;
                        rsp_fill_in   = held_left;
                        held_in       = held_left;
                     end
                  end
                  CMD_DISCARD: begin
                     // take <= held <= slots, so one wrap at most
                     rd_ptr_in    = (rd_sum >= slots_ff) ? PTR_W'(rd_sum - slots_ff)
                                                         : PTR_W'(rd_sum);
                     held_in      = held_left;
                     rsp_moved_in = take;
                     rsp_fill_in  = held_left;
                     if (held_left == '0) begin
                        rd_ptr_in = '0;
                        wr_ptr_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            ram_re        = 1'b1;
            rd_ptr_in     = advance(rd_ptr_ff, slots_ff);
            remain_in     = remain_ff - LEN_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_has_in    = 1'b1;
            rsp_last_in   = (remain_ff == LEN_W'(1));
            if (remain_ff == LEN_W'(1)) begin
               state_in = ST_IDLE;
               if (held_ff == '0) begin
                  rd_ptr_in = '0;
                  wr_ptr_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         held_ff       <= '0;
         slots_ff      <= CNT_W'(STORE_DEPTH);
         remain_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_has_ff    <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         held_ff       <= held_in;
         slots_ff      <= slots_in;
         remain_ff     <= remain_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_has_ff    <= rsp_has_in;
         rsp_last_ff   <= rsp_last_in;
      end
      rsp_moved_ff <= rsp_moved_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   always_comb begin
      busy                    = (state_ff == ST_POP);
      rsp_strobe              = rsp_strobe_ff;
      rsp_payload.read_byte   = rsp_has_ff ? ram_rd_data : '0;
      rsp_payload.has_byte    = rsp_has_ff;
      rsp_payload.moved_count = rsp_moved_ff;
      rsp_payload.fill_level  = rsp_fill_ff;
      rsp_payload.last        = rsp_last_ff;
   end

endmodule

// ===== rtl/brbf_checker.sv =====
// Port-level checker for the byte ring buffer FIFO, bound to the top level.
// Depends on brbf_pkg and byte_ring_buffer_fifo.
module brbf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input brbf_pkg::rsp_type           rsp_payload
);
   import brbf_pkg::*;

   // busy only starts on a pop transfer
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a command transfer");

   // each busy cycle yields a popped byte in the next cycle
   a_busy_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && rsp_payload.has_byte))
      else $error("pop read produced no result");

   // popped bytes of one command stay back to back until the last
   a_pop_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.has_byte && !rsp_payload.last) |=>
      (rsp_strobe && rsp_payload.has_byte &&
       $stable(rsp_payload.moved_count) && $stable(rsp_payload.fill_level)))
      else $error("pop burst broken or its summary changed");

   // a result without a byte is always the single, final one
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.has_byte) |->
      (rsp_payload.last && rsp_payload.read_byte == '0))
      else $error("byteless result not marked last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.fill_level <= CNT_W'(STORE_DEPTH) &&
                      rsp_payload.moved_count <= LEN_W'(MAX_REQUEST)))
      else $error("result counts out of range");

endmodule

bind byte_ring_buffer_fifo brbf_checker u_brbf_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for byte_ring_buffer_fifo: directed table, then random command traffic.
// A shadow FIFO predicts every result not given by the table. Depends on brbf_pkg and the RTL top level only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import brbf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int LATENCY_GAP = 4;

   typedef struct packed {
      logic              is_csr;
      logic [CNT_W-1:0]  csr_value;
      req_type           req;
      logic              typed;
      logic [LEN_W-1:0]  moved;
      logic [CNT_W-1:0]  fill;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_payload = '0;
   logic             rsp_strobe;
   rsp_type          rsp_payload;
   logic             csr_write_enable = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;

   // shadow copy of the FIFO state
   logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
   int                shadow_rd = 0;
   int                shadow_wr = 0;
   int                shadow_held = 0;
   logic [CNT_W-1:0]  shadow_cap = CNT_W'(STORE_DEPTH);

   rsp_type     step_rsp [$];
   rsp_type     expected_rsp_q [$];
   dir_row_type directed_rows [$];
   int          sender_idle_pct = 0;
   int          mismatch_count = 0;

   always #6 clock = ~clock;

   byte_ring_buffer_fifo i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
   endtask

   // Results of one command against the shadow FIFO, left in step_rsp.
   function automatic void predict_fifo_cmd(input req_type r);
      int slots;
      int len;
      int n;
      rsp_type o;
      slots = (shadow_cap == 0) ? 1 :
              ((shadow_cap > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_cap));
      len = (r.length > MAX_REQUEST) ? MAX_REQUEST : int'(r.length);
      step_rsp.delete();
      o = '0;
      o.last = 1'b1;
      case (r.command)
         CMD_PUSH: begin
            if (shadow_held < slots) begin
               shadow_store[PTR_W'(shadow_wr)] = r.data_byte;
               shadow_wr = (shadow_wr + 1 >= slots) ? 0 : shadow_wr + 1;
               shadow_held++;
               o.moved_count = LEN_W'(1);
            end
            o.fill_level = CNT_W'(shadow_held);
            step_rsp.push_back(o);
         end
         CMD_POP, CMD_DISCARD: begin
            n = (len < shadow_held) ? len : shadow_held;
            o.moved_count = LEN_W'(n);
            o.fill_level = CNT_W'(shadow_held - n);
            if (r.command == CMD_DISCARD || n == 0)
               step_rsp.push_back(o);
            for (int i = 0; i < n; i++) begin
               if (r.command == CMD_POP) begin
                  o.read_byte = shadow_store[PTR_W'(shadow_rd)];
                  o.has_byte = 1'b1;
                  o.last = (i == n - 1);
                  step_rsp.push_back(o);
               end
               shadow_rd = (shadow_rd + 1 >= slots) ? 0 : shadow_rd + 1;
            end
            shadow_held -= n;
            if (shadow_held == 0) begin
               shadow_rd = 0;
               shadow_wr = 0;
            end
         end
         default: begin
            o.fill_level = CNT_W'(shadow_held);
            step_rsp.push_back(o);
         end
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic issue(input req_type r, input bit typed, input rsp_type typed_rsp);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      predict_fifo_cmd(r);
      if (typed)
         expected_rsp_q.push_back(typed_rsp);
      else
         foreach (step_rsp[i]) expected_rsp_q.push_back(step_rsp[i]);
      @(negedge clock);
   endtask

   // Capacity writes only once the FIFO has drained all pending results.
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (LATENCY_GAP) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_cap  = value;
      shadow_rd   = 0;
      shadow_wr   = 0;
      shadow_held = 0;
   endtask

   function automatic req_type random_req();
      req_type r;
      r.command   = CMD_W'($urandom_range(0, 3));
      r.data_byte = BYTE_W'($urandom_range(0, 255));
      r.length    = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 127))
                                                : LEN_W'($urandom_range(0, 10));
      return r;
   endfunction

   function automatic void row_cmd(input logic [CMD_W-1:0] cmd, input int data, input int len);
      dir_row_type d;
      d = '0;
      d.req = '{command: cmd, data_byte: BYTE_W'(data), length: LEN_W'(len)};
      directed_rows.push_back(d);
   endfunction

   function automatic void row_chk(input logic [CMD_W-1:0] cmd, input int data, input int len,
                                   input int moved, input int fill);
      dir_row_type d;
      d = '0;
      d.req = '{command: cmd, data_byte: BYTE_W'(data), length: LEN_W'(len)};
      d.typed = 1'b1;
      d.moved = LEN_W'(moved);
      d.fill  = CNT_W'(fill);
      directed_rows.push_back(d);
   endfunction

   function automatic void row_csr(input int value);
      dir_row_type d;
      d = '0;
      d.is_csr = 1'b1;
      d.csr_value = CNT_W'(value);
      directed_rows.push_back(d);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with nothing pending, fill", int'(rsp_payload.fill_level), 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_payload.read_byte !== want.read_byte)
               report_mismatch("read_byte", int'(rsp_payload.read_byte), int'(want.read_byte));
            if (rsp_payload.has_byte !== want.has_byte)
               report_mismatch("has_byte", int'(rsp_payload.has_byte), int'(want.has_byte));
            if (rsp_payload.moved_count !== want.moved_count)
               report_mismatch("moved_count", int'(rsp_payload.moved_count),
                               int'(want.moved_count));
            if (rsp_payload.fill_level !== want.fill_level)
               report_mismatch("fill_level", int'(rsp_payload.fill_level),
                               int'(want.fill_level));
            if (rsp_payload.last !== want.last)
               report_mismatch("last", int'(rsp_payload.last), int'(want.last));
         end
      end
   end

   initial begin
      rsp_type          typed_rsp;
      req_type          r;
      logic [CNT_W-1:0] cap;
      int               sent;
      int               burst_len;

      // capacity is 1024 out of reset
      row_chk(CMD_POP,     8'h00,   5, 0, 0);
      row_chk(CMD_DISCARD, 8'h00,   0, 0, 0);
      row_chk(CMD_UNUSED,  8'hFF, 127, 0, 0);
      row_chk(CMD_PUSH,    8'h00,   0, 1, 1);
      row_chk(CMD_PUSH,    8'hFF, 127, 1, 2);
      row_chk(CMD_PUSH,    8'hA5,   0, 1, 3);
      row_chk(CMD_UNUSED,  8'h00,   0, 0, 3);
      row_chk(CMD_POP,     8'hFF,   0, 0, 3);
      row_cmd(CMD_POP,     8'h00, 127);
      row_chk(CMD_PUSH,    8'h3C,   0, 1, 1);
      row_chk(CMD_DISCARD, 8'hFF,  64, 1, 0);
      row_csr(0);                            // zero capacity acts as one slot
      row_chk(CMD_PUSH,    8'h11,   0, 1, 1);
      row_chk(CMD_PUSH,    8'h22,   0, 0, 1);
      row_cmd(CMD_POP,     8'h00,   1);
      row_csr(2047);                         // saturates to the store depth
      row_chk(CMD_PUSH,    8'h7E,   0, 1, 1);
      row_chk(CMD_PUSH,    8'h81,   0, 1, 2);
      row_chk(CMD_DISCARD, 8'h00, 127, 2, 0);
      row_csr(3);
      row_chk(CMD_PUSH,    8'h01,   0, 1, 1);
      row_chk(CMD_PUSH,    8'h02,   0, 1, 2);
      row_chk(CMD_PUSH,    8'h03,   0, 1, 3);
      row_chk(CMD_PUSH,    8'h04,   0, 0, 3);
      row_cmd(CMD_POP,     8'h00,   2);
      row_chk(CMD_PUSH,    8'h05,   0, 1, 2);
      row_chk(CMD_PUSH,    8'h06,   0, 1, 3);
      row_cmd(CMD_POP,     8'h00,  64);
      row_csr(1);
      row_chk(CMD_PUSH,    8'h80,   0, 1, 1);
      row_chk(CMD_DISCARD, 8'h00,   1, 1, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_capacity(directed_rows[i].csr_value);
         end else begin
            typed_rsp = '0;
            typed_rsp.moved_count = directed_rows[i].moved;
            typed_rsp.fill_level  = directed_rows[i].fill;
            typed_rsp.last        = 1'b1;
            issue(directed_rows[i].req, directed_rows[i].typed, typed_rsp);
         end
      end

      typed_rsp = '0;
      for (int mode = 0; mode < 3; mode++) begin
         sender_idle_pct = (mode == 0) ? 34 : ((mode == 1) ? 67 : 0);
         for (int seg = 0; seg < 2; seg++) begin
            case (mode * 2 + seg)
               0:       cap = CNT_W'(1);
               1:       cap = CNT_W'($urandom_range(2, 40));
               2:       cap = CNT_W'(0);
               3:       cap = CNT_W'($urandom_range(41, 1024));
               4:       cap = CNT_W'(2047);
               default: cap = CNT_W'($urandom_range(1025, 2046));
            endcase
            write_capacity(cap);
            sent = 0;
            while (sent < 32) begin
               if ($urandom_range(0, 9) < 7) begin
                  // fill burst followed by a drain, random content
                  burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 66)
                                                          : $urandom_range(1, 8);
                  repeat (burst_len) begin
                     r = random_req();
                     r.command = CMD_PUSH;
                     issue(r, 1'b0, typed_rsp);
                  end
                  r = random_req();
                  r.command = ($urandom_range(0, 3) == 0) ? CMD_DISCARD : CMD_POP;
                  if ($urandom_range(0, 1) == 0)
                     r.length = LEN_W'(burst_len + $urandom_range(0, 2));
                  issue(r, 1'b0, typed_rsp);
                  sent += burst_len + 1;
               end else begin
                  issue(random_req(), 1'b0, typed_rsp);
                  sent++;
               end
            end
         end
      end

      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/brbf_pkg.sv
rtl/brbf_ram.sv
rtl/byte_ring_buffer_fifo.sv
rtl/brbf_checker.sv
tb/tb_top.sv
